FILE: sv/aie_pkg.sv
package aie_pkg;

  // instruction codes
  typedef enum logic [3:0] {
    OP_LDR0   = 4'd0,
    OP_LDR1   = 4'd1,
    OP_LDR0I  = 4'd2,
    OP_LDR1I  = 4'd3,
    OP_STR0   = 4'd4,
    OP_STR1   = 4'd5,
    OP_ADDI   = 4'd6,
    OP_ADD    = 4'd7,
    OP_SUBI   = 4'd8,
    OP_SUB    = 4'd9,
    OP_JMP    = 4'd10,
    OP_JNZ    = 4'd11,
    OP_TESTZ  = 4'd12,
    OP_TESTGT = 4'd13
  } op_e;

  localparam int unsigned OpWidth      = 4;
  localparam int unsigned ByteWidth    = 8;
  localparam int unsigned RegCntWidth  = 2;
  localparam int unsigned MemSizeWidth = 9;
  localparam int unsigned CfgIdxWidth  = 1;
  localparam int unsigned CfgDataWidth = 9;

  // configuration register indexes
  localparam logic [CfgIdxWidth-1:0] CFG_REG_COUNT = 1'b0;
  localparam logic [CfgIdxWidth-1:0] CFG_MEM_SIZE  = 1'b1;

  // values after reset
  localparam logic [RegCntWidth-1:0]  REG_COUNT_RST = 2'd2;
  localparam logic [MemSizeWidth-1:0] MEM_SIZE_RST  = 9'd256;

endpackage

FILE: sv/aie_req_if.sv
interface aie_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [aie_pkg::OpWidth-1:0]          req_type;
  logic [aie_pkg::ByteWidth-1:0]        operand;

  modport source (output valid, output req_type, output operand, input ready);
  modport sink   (input valid, input req_type, input operand, output ready);
endinterface

FILE: sv/aie_rsp_if.sv
interface aie_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          ok;
  logic                          jump_taken;
  logic [aie_pkg::ByteWidth-1:0] jump_target;
  logic [aie_pkg::ByteWidth-1:0] reg0_value;
  logic [aie_pkg::ByteWidth-1:0] reg1_value;
  logic                          zero_flag_out;

  modport source (output valid, output ok, output jump_taken, output jump_target,
                  output reg0_value, output reg1_value, output zero_flag_out,
                  input ready);
  modport sink   (input valid, input ok, input jump_taken, input jump_target,
                  input reg0_value, input reg1_value, input zero_flag_out,
                  output ready);
endinterface

FILE: sv/aie_cfg_if.sv
interface aie_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [aie_pkg::CfgIdxWidth-1:0]  index;
  logic [aie_pkg::CfgDataWidth-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: sv/aie_dmem.sv
module aie_dmem #(
  parameter int unsigned MEM_DEPTH = 256
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                rd_en_i,
  input  logic [$clog2(MEM_DEPTH)-1:0]        rd_addr_i,
  input  logic                                wr_en_i,
  input  logic [$clog2(MEM_DEPTH)-1:0]        wr_addr_i,
  input  logic [aie_pkg::ByteWidth-1:0]       wr_data_i,
  output logic [aie_pkg::ByteWidth-1:0]       rd_data_o,
  output logic                                busy_o
);

  localparam int unsigned AddrWidth = $clog2(MEM_DEPTH);

  logic [aie_pkg::ByteWidth-1:0] mem_q [MEM_DEPTH];
  logic [aie_pkg::ByteWidth-1:0] rd_data_q;
  logic                          clr_busy_q, clr_busy_d;
  logic [AddrWidth-1:0]          clr_addr_q, clr_addr_d;

  // clearing sweep after reset, one entry a cycle
  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_addr_d = clr_addr_q;
    if (clr_busy_q) begin
      clr_addr_d = clr_addr_q + AddrWidth'(1);
      if (clr_addr_q == AddrWidth'(MEM_DEPTH - 1)) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  // write-first read: a store in the same cycle is passed straight on
  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem_q[clr_addr_q] <= '0;
    end else if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
        rd_data_q <= wr_data_i;
      end else begin
        rd_data_q <= mem_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_data_q;
  assign busy_o    = clr_busy_q;

endmodule

FILE: sv/accumulator_instruction_execute.sv
// channel  | modport  | payload                                        | accepted when
// ---------+----------+------------------------------------------------+--------------
// req_i    | sink     | req_type, operand                              | valid & ready
// rsp_o    | source   | ok, jump_taken, jump_target, reg0/1, zero flag | valid & ready
// cfg_i    | sink     | index, data (register count, memory size)      | valid & ready
//
// one item per cycle while the result side is ready and the memory is not being cleared;
// an item passes the execute stage register and then the result register. The memory read
// is issued as the item is registered; execution and write-back happen as the result register is loaded
// after reset the data memory is swept to zero, with req_i not ready until the sweep is done
// a stalled result holds the execute stage; configuration is always ready
module accumulator_instruction_execute #(
  parameter int unsigned MEM_DEPTH  = 256,
  parameter int unsigned DATA_WIDTH = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  aie_req_if.sink   req_i,
  aie_rsp_if.source rsp_o,
  aie_cfg_if.sink   cfg_i
);

  localparam int unsigned AddrWidth = $clog2(MEM_DEPTH);

  // configuration
  logic [aie_pkg::RegCntWidth-1:0]  reg_count_q;
  logic [aie_pkg::MemSizeWidth-1:0] mem_size_q;

  // architectural state
  logic [DATA_WIDTH-1:0] r0_q, r0_d;
  logic [DATA_WIDTH-1:0] r1_q, r1_d;
  logic                  zf_q, zf_d;

  // execute stage (input register)
  logic                            s1_valid_q;
  logic [aie_pkg::OpWidth-1:0]     s1_op_q;
  logic [aie_pkg::ByteWidth-1:0]   s1_arg_q;

  // result register
  logic                          out_valid_q;
  logic                          out_ok_q;
  logic                          out_jump_q;
  logic [aie_pkg::ByteWidth-1:0] out_target_q;
  logic [aie_pkg::ByteWidth-1:0] out_r0_q;
  logic [aie_pkg::ByteWidth-1:0] out_r1_q;
  logic                          out_zf_q;

  // handshakes
  logic in_fire;
  logic s1_adv;
  logic mem_busy;

  // memory hookup
  logic [AddrWidth+7:0]          rd_addr_wide, wr_addr_wide;
  logic [AddrWidth-1:0]          rd_addr, wr_addr;
  logic [aie_pkg::ByteWidth-1:0] mem_rdata;
  logic                          mem_we;
  logic [aie_pkg::ByteWidth-1:0] mem_wdata;

  // decode and execute
  logic                  op_valid, need_mem, need_r1, is_jump;
  logic                  addr_ok, exe_ok, exe_jump;
  logic [DATA_WIDTH-1:0] mem_ext, arg_ext;

  assign s1_adv   = s1_valid_q && (!out_valid_q || rsp_o.ready);
  assign in_fire  = req_i.valid && req_i.ready;
  assign req_i.ready = !mem_busy && (!s1_valid_q || s1_adv);
  assign cfg_i.ready = 1'b1;

  // operand resized to the memory address width
  assign rd_addr_wide = {{AddrWidth{1'b0}}, req_i.operand};
  assign wr_addr_wide = {{AddrWidth{1'b0}}, s1_arg_q};
  assign rd_addr      = rd_addr_wide[AddrWidth-1:0];
  assign wr_addr      = wr_addr_wide[AddrWidth-1:0];

  aie_dmem #(
    .MEM_DEPTH (MEM_DEPTH)
  ) u_dmem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_fire),
    .rd_addr_i (rd_addr),
    .wr_en_i   (mem_we),
    .wr_addr_i (wr_addr),
    .wr_data_i (mem_wdata),
    .rd_data_o (mem_rdata),
    .busy_o    (mem_busy)
  );

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reg_count_q <= aie_pkg::REG_COUNT_RST;
      mem_size_q  <= aie_pkg::MEM_SIZE_RST;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.index)
        aie_pkg::CFG_REG_COUNT: reg_count_q <= cfg_i.data[aie_pkg::RegCntWidth-1:0];
        aie_pkg::CFG_MEM_SIZE:  mem_size_q  <= cfg_i.data[aie_pkg::MemSizeWidth-1:0];
        default: ;
      endcase
    end
  end

  // instruction class decode
  always_comb begin
    op_valid = 1'b1;
    need_mem = 1'b0;
    need_r1  = 1'b0;
    is_jump  = 1'b0;
    case (aie_pkg::op_e'(s1_op_q))
      aie_pkg::OP_LDR0:   need_mem = 1'b1;
      aie_pkg::OP_LDR1:   begin
        need_mem = 1'b1;
        need_r1  = 1'b1;
      end
      aie_pkg::OP_LDR0I:  ;
      aie_pkg::OP_LDR1I:  need_r1 = 1'b1;
      aie_pkg::OP_STR0:   need_mem = 1'b1;
      aie_pkg::OP_STR1:   begin
        need_mem = 1'b1;
        need_r1  = 1'b1;
      end
      aie_pkg::OP_ADDI:   ;
      aie_pkg::OP_ADD:    need_mem = 1'b1;
      aie_pkg::OP_SUBI:   ;
      aie_pkg::OP_SUB:    need_mem = 1'b1;
      aie_pkg::OP_JMP:    is_jump = 1'b1;
      aie_pkg::OP_JNZ:    is_jump = 1'b1;
      aie_pkg::OP_TESTZ:  ;
      aie_pkg::OP_TESTGT: ;
      default:            op_valid = 1'b0;
    endcase
  end

  // address must sit below both the configured size and the real depth
  assign addr_ok = ({1'b0, s1_arg_q} < mem_size_q) && (32'(s1_arg_q) < 32'(MEM_DEPTH));

  // jumps need no register; a register count of three acts as two
  always_comb begin
    exe_ok = op_valid;
    if (!is_jump) begin
      if (reg_count_q == 2'd0 || (need_r1 && reg_count_q == 2'd1)) begin
        exe_ok = 1'b0;
      end
      if (need_mem && !addr_ok) begin
        exe_ok = 1'b0;
      end
    end
  end

  assign mem_ext = DATA_WIDTH'(mem_rdata);
  assign arg_ext = DATA_WIDTH'(s1_arg_q);

  // state update; a failed instruction leaves everything as it was
  always_comb begin
    r0_d      = r0_q;
    r1_d      = r1_q;
    zf_d      = zf_q;
    exe_jump  = 1'b0;
    mem_we    = 1'b0;
    mem_wdata = r0_q[aie_pkg::ByteWidth-1:0];
    if (exe_ok) begin
      case (aie_pkg::op_e'(s1_op_q))
        aie_pkg::OP_LDR0:   r0_d = mem_ext;
        aie_pkg::OP_LDR1:   r1_d = mem_ext;
        aie_pkg::OP_LDR0I:  r0_d = arg_ext;
        aie_pkg::OP_LDR1I:  r1_d = arg_ext;
        aie_pkg::OP_STR0:   mem_we = s1_adv;
        aie_pkg::OP_STR1:   begin
          mem_we    = s1_adv;
          mem_wdata = r1_q[aie_pkg::ByteWidth-1:0];
        end
        aie_pkg::OP_ADDI:   r0_d = r0_q + arg_ext;
        aie_pkg::OP_ADD:    r0_d = r0_q + mem_ext;
        aie_pkg::OP_SUBI:   r0_d = r0_q - arg_ext;
        aie_pkg::OP_SUB:    r0_d = r0_q - mem_ext;
        aie_pkg::OP_JMP:    exe_jump = 1'b1;
        aie_pkg::OP_JNZ:    exe_jump = !zf_q;
        aie_pkg::OP_TESTZ:  zf_d = (r0_q == '0);
        aie_pkg::OP_TESTGT: zf_d = (r0_q > arg_ext);
        default: ;
      endcase
    end
  end

  // execute stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_op_q  <= req_i.req_type;
      s1_arg_q <= req_i.operand;
    end
  end

  // architectural registers commit as the item leaves the execute stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r0_q <= '0;
      r1_q <= '0;
      zf_q <= 1'b0;
    end else if (s1_adv) begin
      r0_q <= r0_d;
      r1_q <= r1_d;
      zf_q <= zf_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_ok_q     <= exe_ok;
      out_jump_q   <= exe_jump;
      out_target_q <= exe_jump ? s1_arg_q : '0;
      out_r0_q     <= r0_d[aie_pkg::ByteWidth-1:0];
      out_r1_q     <= r1_d[aie_pkg::ByteWidth-1:0];
      out_zf_q     <= zf_d;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.ok            = out_ok_q;
  assign rsp_o.jump_taken    = out_jump_q;
  assign rsp_o.jump_target   = out_target_q;
  assign rsp_o.reg0_value    = out_r0_q;
  assign rsp_o.reg1_value    = out_r1_q;
  assign rsp_o.zero_flag_out = out_zf_q;

  // no item is taken while the memory is still being cleared
  a_no_accept_while_clearing: assert property (
    @(posedge clk_i) disable iff (!rst_ni) mem_busy |-> !req_i.ready
  ) else $error("item accepted during memory clear");

  // a failed result never reports a jump
  a_fail_no_jump: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ok_q) |-> (!out_jump_q && out_target_q == '0)
  ) else $error("failed instruction reports a jump");

  // a committed store leaves the registers and flag untouched
  a_store_keeps_regs: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    mem_we |=> ($stable(r0_q) && $stable(r1_q) && $stable(zf_q))
  ) else $error("store changed register state");

endmodule

FILE: dv/tb_accumulator_instruction_execute.sv
module tb_accumulator_instruction_execute;

  // bench timing and run shape
  localparam int unsigned ClkPeriod     = 12;
  localparam int unsigned MemDepth      = 256;
  localparam int unsigned SettleCycles  = 4;       // pipe drain plus margin
  localparam int unsigned TimeoutCycles = 200_000;
  localparam int unsigned NumPhases     = 8;
  localparam int unsigned ItemsPerPhase = 180;

  // request codes the decoder leaves unassigned
  localparam logic [aie_pkg::OpWidth-1:0] OP_SPARE_LO = 4'd14;
  localparam logic [aie_pkg::OpWidth-1:0] OP_SPARE_HI = 4'd15;

  // one result item as the response channel carries it
  typedef struct packed {
    logic                          ok;
    logic                          jump_taken;
    logic [aie_pkg::ByteWidth-1:0] jump_target;
    logic [aie_pkg::ByteWidth-1:0] reg0;
    logic [aie_pkg::ByteWidth-1:0] reg1;
    logic                          zero_flag;
  } exec_result_t;

  // machine state mirror: predicts each result as its instruction is accepted
  class exec_scoreboard;
    logic [aie_pkg::ByteWidth-1:0]    acc0;
    logic [aie_pkg::ByteWidth-1:0]    acc1;
    logic                             zflag;
    logic [aie_pkg::ByteWidth-1:0]    mem [MemDepth];
    logic [aie_pkg::RegCntWidth-1:0]  reg_count;
    logic [aie_pkg::MemSizeWidth-1:0] mem_size;
    exec_result_t                     pending_q[$];
    int unsigned                      mismatches;
    int unsigned                      checked;

    function new();
      acc0       = '0;
      acc1       = '0;
      zflag      = 1'b0;
      reg_count  = aie_pkg::REG_COUNT_RST;
      mem_size   = aie_pkg::MEM_SIZE_RST;
      mismatches = 0;
      checked    = 0;
      for (int i = 0; i < MemDepth; i++) mem[i] = '0;
    endfunction

    function void apply_config(logic [aie_pkg::CfgIdxWidth-1:0] idx,
                               logic [aie_pkg::CfgDataWidth-1:0] data);
      if (idx == aie_pkg::CFG_REG_COUNT) reg_count = data[aie_pkg::RegCntWidth-1:0];
      else                               mem_size  = data[aie_pkg::MemSizeWidth-1:0];
    endfunction

    // execute one instruction on the mirror and queue what the block must return
    function void note_request(logic [aie_pkg::OpWidth-1:0] op,
                               logic [aie_pkg::ByteWidth-1:0] arg);
      exec_result_t                  res;
      logic                          need_mem;
      logic                          need_r1;
      logic                          is_jump;
      logic                          ok;
      logic [aie_pkg::ByteWidth-1:0] data;
      need_mem = 1'b0;
      need_r1  = 1'b0;
      is_jump  = 1'b0;
      case (op)
        aie_pkg::OP_LDR0, aie_pkg::OP_STR0, aie_pkg::OP_ADD, aie_pkg::OP_SUB: need_mem = 1'b1;
        aie_pkg::OP_LDR1, aie_pkg::OP_STR1: begin
          need_mem = 1'b1;
          need_r1  = 1'b1;
        end
        aie_pkg::OP_LDR1I:                need_r1 = 1'b1;
        aie_pkg::OP_JMP, aie_pkg::OP_JNZ: is_jump = 1'b1;
        default: ;
      endcase
      // spare codes fail; jumps skip every check; count three acts as two
      ok = (op <= aie_pkg::OP_TESTGT);
      if (ok && !is_jump) begin
        if (reg_count == 0 || (need_r1 && reg_count == 1)) ok = 1'b0;
        if (need_mem && !(arg < mem_size && arg < MemDepth)) ok = 1'b0;
      end
      res  = '0;
      data = mem[arg];
      if (ok) begin
        case (op)
          aie_pkg::OP_LDR0:   acc0 = data;
          aie_pkg::OP_LDR1:   acc1 = data;
          aie_pkg::OP_LDR0I:  acc0 = arg;
          aie_pkg::OP_LDR1I:  acc1 = arg;
          aie_pkg::OP_STR0:   mem[arg] = acc0;
          aie_pkg::OP_STR1:   mem[arg] = acc1;
          aie_pkg::OP_ADDI:   acc0 = acc0 + arg;
          aie_pkg::OP_ADD:    acc0 = acc0 + data;
          aie_pkg::OP_SUBI:   acc0 = acc0 - arg;
          aie_pkg::OP_SUB:    acc0 = acc0 - data;
          aie_pkg::OP_JMP:    res.jump_taken = 1'b1;
          aie_pkg::OP_JNZ:    res.jump_taken = !zflag;
          aie_pkg::OP_TESTZ:  zflag = (acc0 == 0);
          aie_pkg::OP_TESTGT: zflag = (acc0 > arg);
          default: ;
        endcase
      end
      res.ok          = ok;
      res.jump_target = res.jump_taken ? arg : '0;
      res.reg0        = acc0;
      res.reg1        = acc1;
      res.zero_flag   = zflag;
      pending_q.push_back(res);
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      mismatches++;
    endtask

    task compare_field(string name, logic [aie_pkg::ByteWidth-1:0] got,
                       logic [aie_pkg::ByteWidth-1:0] want);
      if (got !== want)
        report($sformatf("result %0d %s got %0h expected %0h", checked, name, got, want));
    endtask

    task check_response(exec_result_t got);
      exec_result_t want;
      if (pending_q.size() == 0) begin
        report($sformatf("result %h arrived with nothing outstanding", got));
        return;
      end
      want = pending_q.pop_front();
      compare_field("ok", 8'(got.ok), 8'(want.ok));
      compare_field("jump_taken", 8'(got.jump_taken), 8'(want.jump_taken));
      compare_field("jump_target", got.jump_target, want.jump_target);
      compare_field("reg0_value", got.reg0, want.reg0);
      compare_field("reg1_value", got.reg1, want.reg1);
      compare_field("zero_flag_out", 8'(got.zero_flag), 8'(want.zero_flag));
      checked++;
    endtask
  endclass

  logic clk_i;
  logic rst_ni;

  aie_req_if req_if ();
  aie_rsp_if rsp_if ();
  aie_cfg_if cfg_if ();

  exec_scoreboard sb;

  // idle odds in percent, changed per phase
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  // one setting per random phase; extremes and out-of-range sizes included
  logic [aie_pkg::RegCntWidth-1:0]  phase_reg_count [NumPhases] =
    '{2'd2, 2'd1, 2'd3, 2'd2, 2'd0, 2'd2, 2'd3, 2'd2};
  logic [aie_pkg::MemSizeWidth-1:0] phase_mem_size  [NumPhases] =
    '{9'd256, 9'd40, 9'h1FF, 9'd16, 9'd256, 9'd0, 9'd200, 9'd256};

  accumulator_instruction_execute #(
    .MEM_DEPTH (MemDepth),
    .DATA_WIDTH(aie_pkg::ByteWidth)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if),
    .cfg_i (cfg_if)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // result side: sample before the edge settles, then pick the next ready
  always @(posedge clk_i) begin : rsp_sink
    exec_result_t got;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      got.ok          = rsp_if.ok;
      got.jump_taken  = rsp_if.jump_taken;
      got.jump_target = rsp_if.jump_target;
      got.reg0        = rsp_if.reg0_value;
      got.reg1        = rsp_if.reg1_value;
      got.zero_flag   = rsp_if.zero_flag_out;
      sb.check_response(got);
    end
    rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // present one instruction, maybe after a random gap, and hold it until taken
  task automatic send_request(logic [aie_pkg::OpWidth-1:0] op,
                              logic [aie_pkg::ByteWidth-1:0] arg);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid    <= 1'b1;
    req_if.req_type <= op;
    req_if.operand  <= arg;
    do @(posedge clk_i); while (!(req_if.valid && req_if.ready));
    sb.note_request(op, arg);
  endtask

  // only called with the pipe empty
  task automatic write_config(logic [aie_pkg::CfgIdxWidth-1:0] idx,
                              logic [aie_pkg::CfgDataWidth-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (!(cfg_if.valid && cfg_if.ready));
    cfg_if.valid <= 1'b0;
    sb.apply_config(idx, data);
    @(posedge clk_i);
  endtask

  // stop sending, let every outstanding result come back, then a few quiet cycles
  task automatic wait_drain();
    req_if.valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // mostly a small window of low addresses so stores get read back,
  // sometimes right at the memory size boundary, sometimes anywhere
  function automatic logic [aie_pkg::ByteWidth-1:0] pick_address();
    int unsigned roll;
    int          near;
    roll = $urandom_range(99);
    if (roll < 60) return 8'($urandom_range(15));
    if (roll < 85) begin
      near = int'(sb.mem_size) - 2 + int'($urandom_range(3));
      if (near < 0) near = 0;
      if (near > 255) near = 255;
      return 8'(near);
    end
    return 8'($urandom);
  endfunction

  function automatic logic [aie_pkg::ByteWidth-1:0] pick_operand();
    return $urandom_range(1) ? pick_address() : 8'($urandom);
  endfunction

  // mostly short programs (load, arithmetic, store, read back, test, branch)
  // with random content; the rest single items of any code, spare ones too
  task automatic run_random(int unsigned count);
    int unsigned                   sent;
    logic [aie_pkg::ByteWidth-1:0] addr;
    sent = 0;
    while (sent < count) begin
      addr = pick_address();
      if ($urandom_range(99) < 70) begin
        if ($urandom_range(1)) send_request(aie_pkg::OP_LDR0I, 8'($urandom));
        else                   send_request(aie_pkg::OP_LDR0, pick_address());
        send_request(4'(aie_pkg::OP_ADDI + $urandom_range(3)), pick_operand());
        send_request(aie_pkg::OP_STR0, addr);
        send_request(aie_pkg::OP_LDR1, addr);
        send_request(aie_pkg::OP_STR1, pick_address());
        if ($urandom_range(1)) send_request(aie_pkg::OP_TESTZ, 8'($urandom));
        else                   send_request(aie_pkg::OP_TESTGT, 8'($urandom));
        if ($urandom_range(3) != 0) send_request(aie_pkg::OP_JNZ, 8'($urandom));
        else                        send_request(aie_pkg::OP_JMP, 8'($urandom));
        sent += 7;
      end else begin
        send_request(4'($urandom_range(15)), pick_operand());
        sent++;
      end
    end
  endtask

  // main sequence
  initial begin
    sb              = new();
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    req_if.valid    = 1'b0;
    req_if.req_type = aie_pkg::OP_LDR0;
    req_if.operand  = '0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = aie_pkg::CFG_REG_COUNT;
    cfg_if.data     = '0;
    send_idle_pct   = 7;
    recv_idle_pct   = 50;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // extremes of every field under the reset setting; the memory clear
    // after reset simply holds off the first acceptance
    send_request(aie_pkg::OP_LDR0I, 8'hFF);
    send_request(aie_pkg::OP_STR0, 8'hFF);    // top address
    send_request(aie_pkg::OP_LDR1I, 8'h00);
    send_request(aie_pkg::OP_STR1, 8'h00);
    send_request(aie_pkg::OP_LDR1, 8'hFF);
    send_request(aie_pkg::OP_LDR0, 8'h00);
    send_request(aie_pkg::OP_TESTZ, 8'h00);   // flag set, so the next branch falls through
    send_request(aie_pkg::OP_JNZ, 8'h5A);
    send_request(aie_pkg::OP_ADDI, 8'hFF);
    send_request(aie_pkg::OP_ADD, 8'hFF);     // wraps past 8 bits
    send_request(aie_pkg::OP_SUBI, 8'hFF);    // wraps below zero
    send_request(aie_pkg::OP_TESTGT, 8'hFE);
    send_request(aie_pkg::OP_TESTGT, 8'hFF);  // flag clear, so the next branch is taken
    send_request(aie_pkg::OP_JNZ, 8'hA5);
    send_request(OP_SPARE_LO, 8'h33);
    send_request(OP_SPARE_HI, 8'hCC);
    wait_drain();

    // register count three behaves as two
    write_config(aie_pkg::CFG_REG_COUNT, 9'd3);
    send_request(aie_pkg::OP_LDR1I, 8'h80);
    send_request(aie_pkg::OP_STR1, 8'h10);
    wait_drain();

    // no usable register: only jumps go through
    write_config(aie_pkg::CFG_REG_COUNT, 9'd0);
    send_request(aie_pkg::OP_LDR0I, 8'h01);
    send_request(aie_pkg::OP_JMP, 8'hFF);
    wait_drain();

    // one register: r0 works, r1 fails
    write_config(aie_pkg::CFG_REG_COUNT, 9'd1);
    send_request(aie_pkg::OP_LDR0I, 8'h01);
    send_request(aie_pkg::OP_LDR1I, 8'h02);
    wait_drain();

    // empty memory, then a boundary inside it, then a size past the depth
    write_config(aie_pkg::CFG_MEM_SIZE, 9'd0);
    send_request(aie_pkg::OP_LDR0, 8'h00);
    wait_drain();
    write_config(aie_pkg::CFG_MEM_SIZE, 9'd100);
    send_request(aie_pkg::OP_STR0, 8'd99);
    send_request(aie_pkg::OP_LDR0, 8'd100);
    wait_drain();
    write_config(aie_pkg::CFG_MEM_SIZE, 9'h1FF);
    send_request(aie_pkg::OP_STR0, 8'hFF);
    wait_drain();

    // random phases: sender light / receiver heavy, then swapped, then none
    for (int p = 0; p < NumPhases; p++) begin
      write_config(aie_pkg::CFG_REG_COUNT, aie_pkg::CfgDataWidth'(phase_reg_count[p]));
      write_config(aie_pkg::CFG_MEM_SIZE, aie_pkg::CfgDataWidth'(phase_mem_size[p]));
      if (p < 3) begin
        send_idle_pct = 7;
        recv_idle_pct = 50;
      end else if (p < 6) begin
        send_idle_pct = 50;
        recv_idle_pct = 7;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      run_random(ItemsPerPhase);
      wait_drain();
    end

    if (sb.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(TimeoutCycles * ClkPeriod);
    $display("Verification failed");
    $finish;
  end

endmodule

FILE: files.f
sv/aie_pkg.sv
sv/aie_req_if.sv
sv/aie_rsp_if.sv
sv/aie_cfg_if.sv
sv/aie_dmem.sv
sv/accumulator_instruction_execute.sv
dv/tb_accumulator_instruction_execute.sv
